// ===== design/spn16_pkg.sv =====
// Shared types and functions for the 16-bit SPN cipher.
// S-box tables, bit transposition and the per-cell control and key structs.
// No dependencies.
package spn16_pkg;

	localparam int BlockW  = 16;
	localparam int KeyW    = 32;
	localparam int NumCell = 4;

	localparam logic FUNC_ENC = 1'b0;
	localparam logic FUNC_DEC = 1'b1;

	typedef logic [BlockW-1:0] block_t;

	typedef struct packed {
		logic valid;
		logic func;
	} ctrl_t;

	// Keys and transposition enables seen by one round cell, for both directions.
	typedef struct packed {
		block_t enc_pre;
		block_t enc_post;
		logic   enc_perm;
		block_t dec_pre;
		block_t dec_post;
		logic   dec_perm;
	} round_keys_t;

	localparam logic [3:0] SBOX_FWD [16] = '{
		4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
		4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
	};

	localparam logic [3:0] SBOX_INV [16] = '{
		4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
		4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
	};

	localparam logic [3:0] BIT_DEST [16] = '{
		4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
		4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
	};

	function automatic block_t sub_nibbles(input block_t v, input logic inv);
		block_t r;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			if (inv)
				r[4*i +: 4] = SBOX_INV[v[4*i +: 4]];
			else
				r[4*i +: 4] = SBOX_FWD[v[4*i +: 4]];
		end
		return r;
	endfunction

	function automatic block_t transpose_bits(input block_t v);
		block_t r;
		r = '0;
		for (int i = 0; i < BlockW; i++)
			r[BIT_DEST[i]] = v[i];
		return r;
	endfunction

endpackage

// ===== design/spn16_round_cell.sv =====
// One round cell of the SPN pipeline: key mix, S-box layer, transposition.
// Holds one block and its operation; uses spn16_pkg.
module spn16_round_cell import spn16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  ctrl_t       ctrl_in,
	input  block_t      data_in,
	input  round_keys_t keys,
	output ctrl_t       ctrl_out,
	output block_t      data_out
);

	ctrl_t  ctrl_q;
	block_t data_q;
	block_t result;

	// Encrypt: xor, sbox, transpose, xor. Decrypt: xor, transpose, inverse sbox, xor.
	always_comb begin
		block_t x;
		x = data_in ^ ((ctrl_in.func == FUNC_DEC) ? keys.dec_pre : keys.enc_pre);
		if (ctrl_in.func == FUNC_DEC && keys.dec_perm)
			x = transpose_bits(x);
		x = sub_nibbles(x, ctrl_in.func == FUNC_DEC);
		if (ctrl_in.func == FUNC_ENC && keys.enc_perm)
			x = transpose_bits(x);
		result = x ^ ((ctrl_in.func == FUNC_DEC) ? keys.dec_post : keys.enc_post);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (load) begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign ctrl_out = ctrl_q;
	assign data_out = data_q;

endmodule

// ===== design/spn16_block_cipher.sv =====
// Top level of the 16-bit SPN block cipher: key register and a row of four round cells.
// Uses spn16_pkg and spn16_round_cell.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the 32-bit cipher key. cfg_ready is
//   always high; write only while no request is in flight, the cells read the key live.
//   Input channel (in_valid/in_ready) takes a request: func (0 encrypt, 1 decrypt) and
//   block_in. Output channel (out_valid/out_ready) returns block_out, in request order.
// Path: an accepted request passes through the registers of cells 0, 1, 2 and 3 in order,
//   one round per cell; the last cell's register is the output register, and out_valid
//   is its valid bit.
// Throughput: one request per cycle while out_ready is high.
// Stall: a cell holds its request while the one after it is full and cannot move;
//   empty cells still fill, so up to four requests are buffered while the receiver stalls.
// Reset: all cells empty, key cleared to zero.
module spn16_block_cipher import spn16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] block_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] block_out
);

	logic [KeyW-1:0] key_q;

	ctrl_t       ctrl  [NumCell+1];
	block_t      data  [NumCell+1];
	logic        load  [NumCell+1];
	round_keys_t keys  [NumCell];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			key_q <= cfg_data;
		end
	end

	assign ctrl[0].valid = in_valid;
	assign ctrl[0].func  = func;
	assign data[0]       = block_in;

	// load[i] moves a request into cell i; load[NumCell] is the receiver taking one.
	assign load[NumCell] = out_ready;

	genvar s;
	generate
		for (s = 0; s < NumCell; s++) begin : g_cell
			localparam int EncShift = 16 - 4*s;
			localparam int DecShift = 4 + 4*s;

			assign load[s] = !ctrl[s+1].valid || load[s+1];

			// Encrypt uses K(s+1) up front, K5 after the last S-box layer.
			// Decrypt starts with K5, then K4, K3, K2, K1 after each inverse S-box layer.
			assign keys[s].enc_pre  = key_q[EncShift +: BlockW];
			assign keys[s].enc_post = (s == NumCell-1) ? key_q[BlockW-1:0] : '0;
			assign keys[s].enc_perm = (s != NumCell-1);
			assign keys[s].dec_pre  = (s == 0) ? key_q[BlockW-1:0] : '0;
			assign keys[s].dec_post = key_q[DecShift +: BlockW];
			assign keys[s].dec_perm = (s != 0);

			spn16_round_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.load     (load[s]),
				.ctrl_in  (ctrl[s]),
				.data_in  (data[s]),
				.keys     (keys[s]),
				.ctrl_out (ctrl[s+1]),
				.data_out (data[s+1])
			);
		end
	endgenerate

	assign in_ready  = load[0];
	assign out_valid = ctrl[NumCell].valid;
	assign block_out = data[NumCell];

endmodule
